@@ rtl/core/sfprng_pkg.sv @@
// Constants, types and helper functions of the small fast generator.
package sfprng_pkg;

	localparam int WARMUP_ROUNDS = 20;
	localparam int DIV_STEPS     = 32;
	localparam int FLT_DRAWS     = 5;
	localparam int ROT_A         = 27;
	localparam int ROT_B         = 17;
	localparam int CNT_MAX       = (WARMUP_ROUNDS > DIV_STEPS) ? WARMUP_ROUNDS : DIV_STEPS;
	localparam int CNT_W         = $clog2(CNT_MAX + 1);

	localparam logic [31:0] SEED_CONST = 32'hf1ea5eed;

	localparam logic [2:0] MODE_DRAW32 = 3'd0;
	localparam logic [2:0] MODE_DRAW64 = 3'd1;
	localparam logic [2:0] MODE_RANGE  = 3'd2;
	localparam logic [2:0] MODE_FLOAT  = 3'd3;
	localparam logic [2:0] MODE_SEED   = 3'd4;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} gen_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int k);
		return (x << k) | (x >> (32 - k));
	endfunction

	// one generator round; the new d is the draw
	function automatic gen_t gen_round(input gen_t s);
		gen_t        n;
		logic [31:0] e;
		e   = s.a - rotl32(s.b, ROT_A);
		n.a = s.b ^ rotl32(s.c, ROT_B);
		n.b = s.c + s.d;
		n.c = s.d + e;
		n.d = e + n.a;
		return n;
	endfunction

	// leading zeros of a nonzero word
	function automatic logic [4:0] clz32(input logic [31:0] x);
		logic [31:0] v;
		logic [4:0]  n;
		v = x;
		n = '0;
		if (v[31:16] == 16'h0) begin
			n[4] = 1'b1;
			v = {v[15:0], 16'h0};
		end
		if (v[31:24] == 8'h0) begin
			n[3] = 1'b1;
			v = {v[23:0], 8'h0};
		end
		if (v[31:28] == 4'h0) begin
			n[2] = 1'b1;
			v = {v[27:0], 4'h0};
		end
		if (v[31:30] == 2'h0) begin
			n[1] = 1'b1;
			v = {v[29:0], 2'h0};
		end
		if (v[31] == 1'b0) begin
			n[0] = 1'b1;
		end
		return n;
	endfunction

	// exponent base for each float draw
	function automatic logic [7:0] flt_base(input logic [2:0] idx);
		logic [7:0] r;
		unique case (idx)
			3'd0:    r = 8'd126;
			3'd1:    r = 8'd117;
			3'd2:    r = 8'd85;
			3'd3:    r = 8'd53;
			default: r = 8'd21;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/small_fast_prng_with_range_and_float.sv @@
// Small fast generator with draw32, draw64, ranged draw, unit float and reseed.
// One generator round runs per cycle under a small sequencer; cmd_ready is high only
// when the sequencer is idle. Steps from accept to result in the output register:
// draw32 one round, draw64 a round for each half, ranged draw one round and, unless
// the span wraps to zero, 32 restoring remainder steps on a shared 33-bit subtractor
// and one add, unit float one round per draw. Reseed runs the warm-up rounds and
// gives no word. After reset the block runs the same warm-up with seed zero, with
// cmd_ready low. A finished word waits in the output register while the next
// command is taken.
module small_fast_prng_with_range_and_float (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [2:0]  mode,
	input  logic [31:0] range_low,
	input  logic [31:0] range_high,
	input  logic [31:0] seed_value,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [63:0] value
);
	import sfprng_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RUN  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_FIX  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;
	localparam logic [2:0] ST_WARM = 3'd5;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2:0]       mode_q;
	gen_t             gen_q;
	gen_t             gen_nxt;
	logic [31:0]      lo_q;
	logic [31:0]      span_q;
	logic [31:0]      rem_q;
	logic [31:0]      quo_q;
	logic [31:0]      first_q;
	logic [22:0]      mant_q;
	logic [63:0]      res_q;
	logic [63:0]      value_q;
	logic             res_valid_q;

	logic [31:0] draw;
	logic [32:0] trial;
	logic [32:0] diff;
	logic [31:0] flt_t;
	logic [2:0]  flt_idx;
	logic [22:0] flt_mant;
	logic [7:0]  flt_expo;
	logic        flt_hit;

	assign gen_nxt   = gen_round(gen_q);
	assign draw      = gen_nxt.d;
	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign value     = value_q;

	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, span_q};

	assign flt_idx  = cnt_q[2:0];
	assign flt_mant = (cnt_q == '0) ? draw[22:0] : mant_q;
	always_comb begin
		unique case (flt_idx)
			3'd0:    flt_t = draw & 32'hFF800000;
			3'd4:    flt_t = draw & 32'hFFFFF800;
			default: flt_t = draw;
		endcase
	end
	assign flt_hit  = (flt_t != 32'h0);
	assign flt_expo = flt_hit ? (flt_base(flt_idx) - {3'b000, clz32(flt_t)}) : 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WARM;
			cnt_q       <= '0;
			mode_q      <= MODE_DRAW32;
			gen_q       <= '{a: SEED_CONST, b: 32'h0, c: 32'h0, d: 32'h0};
			lo_q        <= '0;
			span_q      <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			first_q     <= '0;
			mant_q      <= '0;
			res_q       <= '0;
			value_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// the done state reloads the output word itself
			if (res_valid_q && res_ready && state_q != ST_DONE) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						mode_q <= mode;
						lo_q   <= range_low;
						span_q <= range_high + 32'd1 - range_low;
						cnt_q  <= '0;
						unique case (mode)
							MODE_DRAW32, MODE_DRAW64, MODE_RANGE, MODE_FLOAT: begin
								state_q <= ST_RUN;
							end
							MODE_SEED: begin
								gen_q   <= '{a: SEED_CONST, b: seed_value,
									c: seed_value, d: seed_value};
								state_q <= ST_WARM;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_RUN: begin
					gen_q <= gen_nxt;
					unique case (mode_q)
						MODE_DRAW32: begin
							res_q   <= {32'h0, draw};
							state_q <= ST_DONE;
						end
						MODE_DRAW64: begin
							if (cnt_q == '0) begin
								first_q <= draw;
								cnt_q   <= cnt_q + 1'b1;
							end else begin
								res_q   <= {draw, first_q};
								state_q <= ST_DONE;
							end
						end
						MODE_RANGE: begin
							if (span_q == 32'h0) begin
								res_q   <= {32'h0, draw};
								state_q <= ST_DONE;
							end else begin
								quo_q   <= draw;
								rem_q   <= '0;
								cnt_q   <= '0;
								state_q <= ST_DIV;
							end
						end
						default: begin
							// unit float
							mant_q <= flt_mant;
							if (flt_hit || flt_idx == 3'(FLT_DRAWS - 1)) begin
								res_q   <= {32'h0, 1'b0, flt_expo, flt_mant};
								state_q <= ST_DONE;
							end else begin
								cnt_q <= cnt_q + 1'b1;
							end
						end
					endcase
				end
				ST_DIV: begin
					rem_q <= diff[32] ? trial[31:0] : diff[31:0];
					quo_q <= {quo_q[30:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					res_q   <= {32'h0, rem_q + lo_q};
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_valid_q || res_ready) begin
						value_q     <= res_q;
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_WARM: begin
					if (cnt_q == CNT_W'(WARMUP_ROUNDS)) begin
						state_q <= ST_IDLE;
					end else begin
						gen_q <= gen_nxt;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (span_q != 32'h0))
		else $error("remainder step with zero span");

	a_rem_below_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < span_q))
		else $error("partial remainder not below span");

	a_seed_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready && mode == MODE_SEED) |=>
		(state_q == ST_WARM && gen_q.a == SEED_CONST && cnt_q == '0))
		else $error("reseed did not load generator");

	a_float_draws: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && mode_q == MODE_FLOAT) |-> (cnt_q < CNT_W'(FLT_DRAWS)))
		else $error("too many float draws");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && res_valid_q && !res_ready) |=> (state_q == ST_DONE))
		else $error("result dropped while output word pending");

endmodule
